@@ rtl/fit_policy_block_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// fit policy block allocator assertion macros
// shared concurrent assertion forms used by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FPBA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FPBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/fpba_pkg.sv @@
// ----------------------------------------------------------------------------
// fpba_pkg
// types and constants of the fit policy block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpba_pkg;

   localparam int IDX_PORT_W   = 4;
   localparam int SIZE_PORT_W  = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 5;
   localparam int POLICY_W     = 2;
   localparam int BLOCKS_W     = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_IN_USE = 2'd1;

   localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

   localparam logic [BLOCKS_W-1:0] BLOCKS_RESET = 5'd16;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_REQUEST = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

endpackage

@@ rtl/fit_policy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// first, best and worst fit allocator over a table of block free sizes
// ----------------------------------------------------------------------------
// req channel: mode 0 loads req_size_value into table entry req_block_index
//   (indexes at or above NUM_BLOCKS are dropped) and gives no response;
//   mode 1 requests req_size_value bytes and gives one rsp transaction
// rsp channel: granted flag, chosen block, its remaining size and the
//   request's last_request mark echoed as batch_end
// csr port: index 0 fit policy (3 acts as first fit), index 1 blocks in use
// a load is written to the table as it is taken; a request scans the first
//   min(blocks_in_use, NUM_BLOCKS) entries (none with no blocks in use) through
//   the single table read port, one entry per cycle, and one shared comparator;
//   the table update then posts the response and returns to idle
// the response sits in an output register; a request may already be taken
//   and scanned while it waits, and only the table update stalls on it
// reset clears the table through per-entry valid bits, sets fit policy to
//   first fit and blocks in use to 16, and drops any pending response
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fit_policy_block_allocator_macros.svh"

module fit_policy_block_allocator #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic [fpba_pkg::IDX_PORT_W-1:0]       req_block_index,
   input  logic [fpba_pkg::SIZE_PORT_W-1:0]      req_size_value,
   input  logic                                  req_last_request,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_granted,
   output logic [fpba_pkg::IDX_PORT_W-1:0]       rsp_block_number,
   output logic [fpba_pkg::SIZE_PORT_W-1:0]      rsp_remaining_size,
   output logic                                  rsp_batch_end,
   input  logic                                  csr_wr_en,
   input  logic [fpba_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fpba_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int LIM_W = (CNT_W > fpba_pkg::BLOCKS_W) ? CNT_W : fpba_pkg::BLOCKS_W;

   fpba_pkg::state_type st_ff, st_in;

   logic [fpba_pkg::POLICY_W-1:0] policy_ff;
   logic [fpba_pkg::BLOCKS_W-1:0] blocks_ff;

   logic [NUM_BLOCKS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      lim_ff, lim_in;
   logic                  pend_ff, pend_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [SIZE_BITS-1:0]  best_ff, best_in;
   logic [SIZE_BITS-1:0]  size_ff, size_in;
   logic                  last_ff, last_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_granted_ff, rsp_granted_in;
   logic [fpba_pkg::IDX_PORT_W-1:0]  rsp_block_ff, rsp_block_in;
   logic [fpba_pkg::SIZE_PORT_W-1:0] rsp_remain_ff, rsp_remain_in;
   logic                            rsp_batch_ff, rsp_batch_in;

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [SIZE_BITS-1:0]  ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [SIZE_BITS-1:0]  ram_rd_data;

   logic                  req_acc;
   logic                  rsp_busy;
   logic [SIZE_BITS-1:0]  entry_size;
   logic                  entry_fits;
   logic                  entry_take;
   logic [SIZE_BITS-1:0]  new_size;
   logic [LIM_W-1:0]      blocks_ext;

   assign req_acc    = req_valid && req_ready;
   assign rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign entry_size = rd_vld_ff ? ram_rd_data : '0;
   assign entry_fits = entry_size >= size_ff;
   assign new_size   = best_ff - size_ff;
   assign blocks_ext = LIM_W'(blocks_ff);

   always_comb begin
      entry_take = 1'b0;
      if (pend_ff && entry_fits) begin
         if (!found_ff) begin
            entry_take = 1'b1;
         end else begin
            case (policy_ff)
               fpba_pkg::FIT_BEST:  entry_take = entry_size < best_ff;
               fpba_pkg::FIT_WORST: entry_take = entry_size > best_ff;
               default:             entry_take = 1'b0;
            endcase
         end
      end
   end

   fpba_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         fpba_pkg::ST_IDLE: begin
            if (req_acc && req_mode == fpba_pkg::MODE_REQUEST) begin
               st_in = fpba_pkg::ST_SCAN;
            end
         end
         fpba_pkg::ST_SCAN: begin
            if (cnt_ff == lim_ff && !pend_ff) begin
               st_in = fpba_pkg::ST_UPDATE;
            end
         end
         fpba_pkg::ST_UPDATE: begin
            if (!rsp_busy) begin
               st_in = fpba_pkg::ST_IDLE;
            end
         end
         default: st_in = fpba_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_ready      = st_ff == fpba_pkg::ST_IDLE;
      valid_in       = valid_ff;
      cnt_in         = cnt_ff;
      lim_in         = lim_ff;
      pend_in        = 1'b0;
      rd_vld_in      = rd_vld_ff;
      pend_idx_in    = pend_idx_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      best_in        = best_ff;
      size_in        = size_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_block_in   = rsp_block_ff;
      rsp_remain_in  = rsp_remain_ff;
      rsp_batch_in   = rsp_batch_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = pick_ff;
      ram_wr_data    = new_size;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = cnt_ff[IDX_W-1:0];
      case (st_ff)
         fpba_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_mode == fpba_pkg::MODE_LOAD) begin
                  ram_wr_addr = IDX_W'(req_block_index);
                  ram_wr_data = SIZE_BITS'(req_size_value);
                  if (32'(req_block_index) < NUM_BLOCKS) begin
                     ram_wr_en = 1'b1;
                     valid_in[IDX_W'(req_block_index)] = 1'b1;
                  end
               end else begin
                  cnt_in   = '0;
                  found_in = 1'b0;
                  pick_in  = '0;
                  size_in  = SIZE_BITS'(req_size_value);
                  last_in  = req_last_request;
                  lim_in   = (blocks_ext > LIM_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                              : CNT_W'(blocks_ext);
               end
            end
         end
         fpba_pkg::ST_SCAN: begin
            if (cnt_ff != lim_ff) begin
               ram_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = cnt_ff[IDX_W-1:0];
               rd_vld_in   = valid_ff[cnt_ff[IDX_W-1:0]];
               cnt_in      = cnt_ff + 1'b1;
            end
            if (entry_take) begin
               found_in = 1'b1;
               pick_in  = pend_idx_ff;
               best_in  = entry_size;
            end
         end
         fpba_pkg::ST_UPDATE: begin
            if (!rsp_busy) begin
               ram_wr_en      = found_ff;
               rsp_valid_in   = 1'b1;
               rsp_granted_in = found_ff;
               rsp_block_in   = found_ff ? fpba_pkg::IDX_PORT_W'(pick_ff) : '0;
               rsp_remain_in  = found_ff ? fpba_pkg::SIZE_PORT_W'(new_size) : '0;
               rsp_batch_in   = last_ff;
               if (found_ff) begin
                  valid_in[pick_ff] = 1'b1;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= fpba_pkg::ST_IDLE;
         policy_ff    <= fpba_pkg::FIT_FIRST;
         blocks_ff    <= fpba_pkg::BLOCKS_RESET;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         lim_ff       <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         lim_ff       <= lim_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               fpba_pkg::CSR_FIT_POLICY:    policy_ff <= csr_wdata[fpba_pkg::POLICY_W-1:0];
               fpba_pkg::CSR_BLOCKS_IN_USE: blocks_ff <= csr_wdata[fpba_pkg::BLOCKS_W-1:0];
               default:                     policy_ff <= policy_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff      <= rd_vld_in;
      pend_idx_ff    <= pend_idx_in;
      pick_ff        <= pick_in;
      best_ff        <= best_in;
      size_ff        <= size_in;
      last_ff        <= last_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_block_ff   <= rsp_block_in;
      rsp_remain_ff  <= rsp_remain_in;
      rsp_batch_ff   <= rsp_batch_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_block_number   = rsp_block_ff;
   assign rsp_remaining_size = rsp_remain_ff;
   assign rsp_batch_end      = rsp_batch_ff;

   `FPBA_ASSERT_NEXT(a_req_starts_scan, clock, reset,
      req_acc && req_mode == fpba_pkg::MODE_REQUEST, st_ff == fpba_pkg::ST_SCAN,
      "request transaction did not start a scan")

   `FPBA_ASSERT_SAME(a_scan_in_range, clock, reset,
      st_ff == fpba_pkg::ST_SCAN, cnt_ff <= lim_ff && lim_ff <= CNT_W'(NUM_BLOCKS),
      "scan counter beyond the scan limit")

   `FPBA_ASSERT_SAME(a_pick_in_range, clock, reset,
      found_ff && st_ff != fpba_pkg::ST_IDLE, CNT_W'(pick_ff) < lim_ff,
      "chosen block outside the scanned range")

   `FPBA_ASSERT_NEXT(a_update_posts_rsp, clock, reset,
      st_ff == fpba_pkg::ST_UPDATE && !rsp_busy,
      rsp_valid_ff && st_ff == fpba_pkg::ST_IDLE,
      "table update did not post a response")

endmodule

@@ rtl/fpba_ram.sv @@
// ----------------------------------------------------------------------------
// fpba_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
